// File: rtl/rke_pkg.sv
// Shared types and constants for the rolling k-mer encoder.
package rke_pkg;

    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_T    = 8'h54;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [4:0] KMER_SIZE_RESET = 5'd8;

    typedef enum logic
    {
        REG_KMER_SIZE      = 1'b0,
        REG_STRAND_REVERSE = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [7:0] base_char;
        logic       seq_start;
    } in_beat_t;

    typedef struct packed
    {
        logic [31:0] kmer_code;
        logic        kmer_ok;
    } out_beat_t;

    typedef struct packed
    {
        logic [4:0] kmer_size;
        logic       strand_reverse;
    } cfg_t;

    typedef struct packed
    {
        logic      emit;
        out_beat_t beat;
    } step_res_t;

endpackage

// File: rtl/rolling_kmer_encoder.sv
// An accepted input beat goes through the base register, then the result register.
// One base per cycle unless out_stall holds the pipe; base and result registers form a
// two-stage pipe with the k-mer state updated in the step between them.
// The first k bases of a sequence update state but give no result beat.
// Reset clears pipe valids and k-mer state; kmer_size resets to 8, strand to forward.
// Top level of the rolling k-mer encoder.
module rolling_kmer_encoder
    import rke_pkg::*;
#(
    parameter int MAX_K = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_beat_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_beat_t           out_data
);

    cfg_t      cfg;
    step_res_t res;

    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg;
    logic      advance;
    logic      in_take;

    rke_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rke_core #(.MAX_K(MAX_K)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_data_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !advance);
        if (advance)
            out_valid_next = res.emit;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (advance && res.emit)
            out_data_reg <= res.beat;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/rke_regs.sv
// APB configuration registers of the rolling k-mer encoder.
module rke_regs
    import rke_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output cfg_t                cfg
);

    logic [4:0] kmer_size_reg;
    logic       strand_reverse_reg;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_size_reg      <= KMER_SIZE_RESET;
            strand_reverse_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_KMER_SIZE:      kmer_size_reg      <= pwdata[4:0];
                REG_STRAND_REVERSE: strand_reverse_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KMER_SIZE:      prdata = {27'd0, kmer_size_reg};
            REG_STRAND_REVERSE: prdata = {31'd0, strand_reverse_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.kmer_size      = kmer_size_reg;
    assign cfg.strand_reverse = strand_reverse_reg;

endmodule

// File: rtl/rke_core.sv
// Shift-register state and per-base step logic of the rolling k-mer encoder.
module rke_core
    import rke_pkg::*;
#(
    parameter int MAX_K = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_beat_t  item,
    input  cfg_t      cfg,
    output step_res_t res
);

    localparam int KW = $clog2(MAX_K + 1);
    localparam int SW = 2 * MAX_K;
    localparam int CW = (KW > 5) ? KW : 5;

    logic [SW-1:0]    fwd_reg, fwd_next, fwd_cur;
    logic [SW-1:0]    rev_reg, rev_next, rev_cur;
    logic [MAX_K-1:0] hist_reg, hist_next, hist_cur;
    logic [KW-1:0]    warm_reg, warm_next, warm_cur;

    logic [CW-1:0]    ksz;
    logic [KW-1:0]    k_eff;
    logic [KW:0]      two_k;
    logic [SW-1:0]    kmask;
    logic [MAX_K-1:0] hmask;
    logic [7:0]       ch;
    logic [1:0]       code;
    logic             bad;
    logic             emit;
    logic [SW-1:0]    sel;

    always_comb
    begin
        ksz = CW'(cfg.kmer_size);
        if (ksz == '0)
            k_eff = KW'(1);
        else if (ksz > CW'(MAX_K))
            k_eff = KW'(MAX_K);
        else
            k_eff = KW'(ksz);
    end

    assign two_k = {k_eff, 1'b0};
    assign kmask = ~({SW{1'b1}} << two_k);
    assign hmask = ~({MAX_K{1'b1}} << k_eff);

    assign ch = item.base_char & CASE_MASK;

    always_comb
    begin
        bad = 1'b0;
        unique case (ch)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            CHAR_T:  code = BASE_T;
            default:
            begin
                code = BASE_A;
                bad  = 1'b1;
            end
        endcase
    end

    // seq_start restarts from the reset state before the base is taken
    assign fwd_cur  = item.seq_start ? '0 : fwd_reg;
    assign rev_cur  = item.seq_start ? '0 : rev_reg;
    assign hist_cur = item.seq_start ? '1 : hist_reg;
    assign warm_cur = item.seq_start ? '0 : warm_reg;

    assign fwd_next  = ((fwd_cur << 2) | SW'(code)) & kmask;
    assign rev_next  = ((rev_cur >> 2) + (SW'(~code) << (two_k - (KW + 1)'(2)))) & kmask;
    assign hist_next = {hist_cur[MAX_K-2:0], bad};

    assign emit      = (warm_cur >= k_eff);
    assign warm_next = (warm_cur < k_eff) ? warm_cur + KW'(1) : k_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= '0;
            rev_reg  <= '0;
            hist_reg <= '1;
            warm_reg <= '0;
        end
        else if (step)
        begin
            fwd_reg  <= fwd_next;
            rev_reg  <= rev_next;
            hist_reg <= hist_next;
            warm_reg <= warm_next;
        end
    end

    assign sel = cfg.strand_reverse ? rev_next : fwd_next;

    always_comb
    begin
        res.emit = emit;
        if ((hist_next & hmask) == '0)
        begin
            res.beat.kmer_code = 32'(sel);
            res.beat.kmer_ok   = 1'b1;
        end
        else
        begin
            res.beat.kmer_code = '0;
            res.beat.kmer_ok   = 1'b0;
        end
    end

endmodule
